// ===== design/tce_pkg.sv =====
package tce_pkg;

    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [7:0] NEWLINE_CODE = 8'h0A;
    localparam logic [7:0] SPACE_CODE   = 8'h20;
    localparam logic [3:0] NIBBLE_MASK  = 4'hF;

    localparam logic REG_FG_COLOR = 1'b0;
    localparam logic REG_BG_COLOR = 1'b1;

    localparam logic [3:0] FG_RESET = 4'd15;
    localparam logic [3:0] BG_RESET = 4'd0;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  char_code;
        logic [10:0] cell_index;
    } tce_in_t;

    typedef struct packed {
        logic [10:0] cursor_pos;
        logic [7:0]  cell_char;
        logic [7:0]  cell_attr;
    } tce_out_t;

endpackage

// ===== design/tce_cell_ram.sv =====
module tce_cell_ram #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [15:0]   wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [15:0]   rd_data
);

    logic [15:0] mem [DEPTH];
    logic [15:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/text_console_engine.sv =====
// Text console over a grid of ROWS x COLUMNS cells held in one simple dual-port RAM, each
// word holding a character (high byte) and a colour attribute (background in the high nibble).
// Every word in gives exactly one word out, carrying the linear cursor position. A printable
// character or a newline that does not scroll is done straight from idle. A read goes in steps: the
// RAM read is registered, then the cell is captured, then the result word is loaded. A scroll
// copies the grid up one row through the single RAM write port, one cell a cycle, then blanks
// the bottom row. A clear blanks every cell in turn. Any of these can be held while the result
// word waits for the output to drain. Cells hold no defined value until written or cleared,
// and there is no clearing pass after reset. Colours are set over the register port
// (foreground at 0x0, background at 0x4) and should be changed only while the console is idle.
module text_console_engine
    import tce_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  tce_in_t     s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output tce_out_t    m_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int PW    = $clog2(CELLS + 1);
    localparam int CW    = $clog2(COLUMNS + 1);
    localparam int RW    = $clog2(ROWS);
    localparam int IW    = (PW > 11) ? PW : 11;

    localparam logic [PW-1:0] COLS_P    = PW'(COLUMNS);
    localparam logic [PW-1:0] COPY_END  = PW'(CELLS - COLUMNS);
    localparam logic [PW-1:0] LAST_CELL = PW'(CELLS - 1);
    localparam logic [IW-1:0] CELLS_I   = IW'(CELLS);
    localparam logic [CW-1:0] COL_FULL  = CW'(COLUMNS);
    localparam logic [RW-1:0] ROW_LAST  = RW'(ROWS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_COPY,
        S_BLANK,
        S_OUT
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [PW-1:0] lin_reg, lin_next;
    logic [PW-1:0] base_reg, base_next;
    logic [PW-1:0] cnt_reg, cnt_next;
    logic          pend_reg, pend_next;
    logic [7:0]    char_reg, char_next;
    logic          rd_ok_reg, rd_ok_next;
    logic [15:0]   res_reg, res_next;
    logic          m_valid_reg, m_valid_next;
    tce_out_t      m_data_reg, m_data_next;
    logic [3:0]    fg_reg, bg_reg;

    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [15:0]   ram_wdata, ram_rdata;

    logic [7:0]    attr;
    logic          out_free;
    logic          fast;
    logic [IW-1:0] pos_wide;
    logic [IW-1:0] idx_wide;
    logic [PW-1:0] next_base;
    logic [PW-1:0] copy_src;

    tce_cell_ram #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_cell_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // Register port: no wait states, index taken from address bit 2.
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fg_reg <= FG_RESET;
            bg_reg <= BG_RESET;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_FG_COLOR) begin
                fg_reg <= pwdata[3:0] & NIBBLE_MASK;
            end else begin
                bg_reg <= pwdata[3:0] & NIBBLE_MASK;
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_BG_COLOR) begin
            prdata[3:0] = bg_reg;
        end else begin
            prdata[3:0] = fg_reg;
        end
    end

    assign attr      = {bg_reg, fg_reg};
    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == S_IDLE);
    assign pos_wide  = IW'(lin_next);
    assign idx_wide  = IW'(s_data.cell_index);
    assign next_base = base_reg + COLS_P;
    assign copy_src  = cnt_reg + COLS_P;

    always_comb begin
        state_next   = state_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        lin_next     = lin_reg;
        base_next    = base_reg;
        cnt_next     = cnt_reg;
        pend_next    = pend_reg;
        char_next    = char_reg;
        rd_ok_next   = rd_ok_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        ram_we       = 1'b0;
        ram_waddr    = '0;
        ram_wdata    = '0;
        ram_re       = 1'b0;
        ram_raddr    = '0;
        fast         = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    res_next = '0;
                    fast     = 1'b1;
                    case (s_data.opcode)
                        OP_PUT: begin
                            if (s_data.char_code == NEWLINE_CODE) begin
                                col_next = '0;
                                if (row_reg != ROW_LAST) begin
                                    row_next  = row_reg + 1'b1;
                                    base_next = next_base;
                                    lin_next  = next_base;
                                end else begin
                                    lin_next   = base_reg;
                                    cnt_next   = '0;
                                    pend_next  = 1'b0;
                                    fast       = 1'b0;
                                    state_next = S_COPY;
                                end
                            end else if (col_reg == COL_FULL) begin
                                col_next = CW'(1);
                                if (row_reg != ROW_LAST) begin
                                    row_next  = row_reg + 1'b1;
                                    base_next = next_base;
                                    lin_next  = next_base + 1'b1;
                                    ram_we    = 1'b1;
                                    ram_waddr = next_base[AW-1:0];
                                    ram_wdata = {s_data.char_code, attr};
                                end else begin
                                    // Wrap on the bottom row: scroll first, the character
                                    // lands in the first cell of the fresh bottom row.
                                    lin_next   = base_reg + 1'b1;
                                    cnt_next   = '0;
                                    pend_next  = 1'b1;
                                    char_next  = s_data.char_code;
                                    fast       = 1'b0;
                                    state_next = S_COPY;
                                end
                            end else begin
                                col_next  = col_reg + 1'b1;
                                lin_next  = lin_reg + 1'b1;
                                ram_we    = 1'b1;
                                ram_waddr = lin_reg[AW-1:0];
                                ram_wdata = {s_data.char_code, attr};
                            end
                        end
                        OP_CLEAR: begin
                            col_next   = '0;
                            row_next   = '0;
                            lin_next   = '0;
                            base_next  = '0;
                            cnt_next   = '0;
                            pend_next  = 1'b0;
                            fast       = 1'b0;
                            state_next = S_BLANK;
                        end
                        OP_READ: begin
                            rd_ok_next = (idx_wide < CELLS_I);
                            ram_re     = 1'b1;
                            ram_raddr  = idx_wide[AW-1:0];
                            fast       = 1'b0;
                            state_next = S_READ;
                        end
                        default: begin
                            fast = 1'b1;
                        end
                    endcase
                    if (fast) begin
                        if (out_free) begin
                            m_valid_next = 1'b1;
                            m_data_next  = '{cursor_pos: pos_wide[10:0],
                                             cell_char: 8'd0, cell_attr: 8'd0};
                        end else begin
                            state_next = S_OUT;
                        end
                    end
                end
            end
            S_READ: begin
                res_next   = rd_ok_reg ? ram_rdata : 16'd0;
                state_next = S_OUT;
            end
            S_COPY: begin
                // Read cell cnt+COLUMNS and write the cell read in the cycle before to cnt-1.
                if (cnt_reg != '0) begin
                    ram_we    = 1'b1;
                    ram_waddr = AW'(cnt_reg - 1'b1);
                    ram_wdata = ram_rdata;
                end
                if (cnt_reg < COPY_END) begin
                    ram_re    = 1'b1;
                    ram_raddr = copy_src[AW-1:0];
                    cnt_next  = cnt_reg + 1'b1;
                end else begin
                    state_next = S_BLANK;
                end
            end
            S_BLANK: begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg[AW-1:0];
                if (pend_reg && (cnt_reg == COPY_END)) begin
                    ram_wdata = {char_reg, attr};
                end else begin
                    ram_wdata = {SPACE_CODE, attr};
                end
                if (cnt_reg == LAST_CELL) begin
                    pend_next  = 1'b0;
                    res_next   = '0;
                    state_next = S_OUT;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{cursor_pos: pos_wide[10:0],
                                     cell_char: res_reg[15:8], cell_attr: res_reg[7:0]};
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            col_reg     <= '0;
            row_reg     <= '0;
            lin_reg     <= '0;
            base_reg    <= '0;
            cnt_reg     <= '0;
            pend_reg    <= 1'b0;
            rd_ok_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            lin_reg     <= lin_next;
            base_reg    <= base_next;
            cnt_reg     <= cnt_next;
            pend_reg    <= pend_next;
            rd_ok_reg   <= rd_ok_next;
            m_valid_reg <= m_valid_next;
        end
        char_reg   <= char_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_col_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        col_reg <= COL_FULL)
        else $error("cursor column beyond the row width");

    a_lin_track: assert property (@(posedge aclk) disable iff (!aresetn)
        lin_reg == base_reg + PW'(col_reg))
        else $error("linear cursor out of step with row base and column");

    a_base_track: assert property (@(posedge aclk) disable iff (!aresetn)
        base_reg == PW'(row_reg) * COLS_P)
        else $error("row base does not match cursor row");

    a_clear_home: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_data.opcode == OP_CLEAR)
        |=> (state_reg == S_BLANK) && (lin_reg == '0) && (cnt_reg == '0))
        else $error("clear did not home the cursor and start blanking");

endmodule
